FILE: rtl/cdm_pkg.sv
// shared types and constants of the chessboard distance map
package cdm_pkg;

	typedef enum logic [1:0] {
		OP_WRITE    = 2'd0,
		OP_RUN      = 2'd1,
		OP_READ_PIX = 2'd2,
		OP_READ_BIN = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD_WAIT,
		ST_DONE,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_RLX_RD,
		ST_RLX_LAST,
		ST_RLX_WR
	} state_t;

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_POLARITY = 2'd2;

	localparam int CFG_W   = 9;
	localparam int IDX_W   = 16;
	localparam int PIX_W   = 8;
	localparam int BIN_W   = 8;
	localparam int BINS    = 256;
	localparam int VALUE_W = 17;

	localparam logic [VALUE_W-1:0] BIN_MAX = 17'h1FFFF;
	localparam logic [PIX_W-1:0] PIX_FEATURE = 8'd255;
	localparam logic [PIX_W-1:0] PIX_SAT     = 8'd254;

	// neighbor slots: slot zero is the center pixel itself
	localparam int NB_N = 9;
	localparam logic [3:0] NB_LAST = 4'd8;
	localparam logic signed [1:0] NB_DX [NB_N] = '{
		2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1
	};
	localparam logic signed [1:0] NB_DY [NB_N] = '{
		2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1
	};

	typedef struct packed {
		logic             clear;
		logic             inc;
		logic [BIN_W-1:0] bin;
	} hist_cmd_t;

endpackage

FILE: rtl/chessboard_distance_map_top.sv
// top level of the chessboard distance map: config registers, stream ports, result register
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  tuser: operation; tdata: index, value, bin
// m_*       out        m_tvalid/m_tready  tdata: read_value, status
// cfg_*     in         cfg_wr_en          cfg_index, cfg_data
//
// a pixel write or an out of range read goes from accept through EXEC to DONE,
// an in-range distance read or a bin read passes through RD_WAIT as well
// a run marks every pixel, then makes a forward and a backward relax pass;
// the single read port of the image memory fetches one neighbor per cycle
// reset clears the state machine, the result valid flag and all histogram bins
// a result waiting on m_tready holds one request; the next is taken meanwhile

module chessboard_distance_map_top #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel_index[15:0], pixel_value[23:16], bin_index[31:24]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // read_value[16:0], status[17], zero[23:18]
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	import cdm_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int NW = $clog2(DEPTH + 1);
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int HB = $clog2(MAX_HEIGHT + 1);

	logic [CFG_W-1:0]   width_q;
	logic [CFG_W-1:0]   height_q;
	logic               pol_q;
	logic [WB-1:0]      w_eff;
	logic [HB-1:0]      h_eff;
	logic [NW-1:0]      n_q;

	logic               idle;
	logic               res_valid;
	logic               res_ready;
	logic [VALUE_W-1:0] res_value;
	logic               res_status;
	hist_cmd_t          hist_cmd;
	logic [VALUE_W-1:0] hist_rdata;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			pol_q    <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WIDTH:    width_q  <= cfg_data;
				REG_HEIGHT:   height_q <= cfg_data;
				REG_POLARITY: pol_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// zero size counts as one, oversize clamps to the maximum
	always_comb begin
		if (width_q == '0) begin
			w_eff = WB'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HB'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HB'(MAX_HEIGHT);
		end else begin
			h_eff = HB'(height_q);
		end
	end

	always_ff @(posedge clk) begin
		n_q <= NW'(w_eff) * NW'(h_eff);
	end

	assign s_tready  = idle;
	assign res_ready = !out_valid_q || m_tready;

	cdm_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid && s_tready),
		.req_op     (op_t'(s_tuser)),
		.req_pix    (s_tdata[15:0]),
		.req_val    (s_tdata[23:16]),
		.req_bin    (s_tdata[31:24]),
		.idle       (idle),
		.w_eff      (w_eff),
		.h_eff      (h_eff),
		.n_eff      (n_q),
		.polarity   (pol_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_value  (res_value),
		.res_status (res_status),
		.hist_cmd   (hist_cmd),
		.hist_rdata (hist_rdata)
	);

	cdm_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hist_cmd),
		.rdata  (hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_value_q  <= res_value;
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_status_q, out_value_q};

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in work");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res_valid)
		else $error("result offered while the sequencer is idle");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[17]) |-> (m_tdata[16:0] == 17'd0))
		else $error("out of range status with nonzero value");

endmodule

FILE: rtl/cdm_ram.sv
// generic single write port ram with registered read
module cdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/cdm_hist.sv
// histogram store with per-bin valid bits, saturating increment and read
module cdm_hist (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cdm_pkg::hist_cmd_t           cmd,
	output logic [cdm_pkg::VALUE_W-1:0]  rdata
);

	import cdm_pkg::*;

	logic [BINS-1:0]    valid_q;
	logic               inc_s1;
	logic [BIN_W-1:0]   bin_s1;
	logic               wr_vld_q;
	logic [BIN_W-1:0]   wr_bin_q;
	logic [VALUE_W-1:0] wr_data_q;
	logic [VALUE_W-1:0] ram_rd;
	logic [VALUE_W-1:0] cur;
	logic [VALUE_W-1:0] nxt;

	cdm_ram #(.WIDTH(VALUE_W), .DEPTH(BINS)) u_ram (
		.clk     (clk),
		.wr_en   (inc_s1),
		.wr_addr (bin_s1),
		.wr_data (nxt),
		.rd_addr (cmd.bin),
		.rd_data (ram_rd)
	);

	// forward the last write when the same bin is read right behind it
	always_comb begin
		if (wr_vld_q && wr_bin_q == bin_s1) begin
			cur = wr_data_q;
		end else if (valid_q[bin_s1]) begin
			cur = ram_rd;
		end else begin
			cur = '0;
		end
		nxt = (cur < BIN_MAX) ? cur + VALUE_W'(1) : cur;
	end

	assign rdata = cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			inc_s1   <= 1'b0;
			wr_vld_q <= 1'b0;
		end else begin
			inc_s1   <= cmd.inc;
			wr_vld_q <= inc_s1 && !cmd.clear;
			if (cmd.clear) begin
				valid_q <= '0;
			end else if (inc_s1) begin
				valid_q[bin_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		bin_s1    <= cmd.bin;
		wr_bin_q  <= bin_s1;
		wr_data_q <= nxt;
	end

endmodule

FILE: rtl/cdm_ctrl.sv
// sequencer over the image memory: requests, feature marking and both relax passes
module cdm_ctrl #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256,
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1),
	localparam int WB = $clog2(MAX_WIDTH + 1),
	localparam int HB = $clog2(MAX_HEIGHT + 1),
	localparam int XB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int YB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  cdm_pkg::op_t                 req_op,
	input  logic [cdm_pkg::IDX_W-1:0]    req_pix,
	input  logic [cdm_pkg::PIX_W-1:0]    req_val,
	input  logic [cdm_pkg::BIN_W-1:0]    req_bin,
	output logic                         idle,
	input  logic [WB-1:0]                w_eff,
	input  logic [HB-1:0]                h_eff,
	input  logic [NW-1:0]                n_eff,
	input  logic                         polarity,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [cdm_pkg::VALUE_W-1:0]  res_value,
	output logic                         res_status,
	output cdm_pkg::hist_cmd_t           hist_cmd,
	input  logic [cdm_pkg::VALUE_W-1:0]  hist_rdata
);

	import cdm_pkg::*;

	state_t             state_q, state_d;
	op_t                op_q;
	logic [IDX_W-1:0]   pix_q;
	logic [PIX_W-1:0]   val_q;
	logic [BIN_W-1:0]   bin_q;
	logic [AW-1:0]      idx_q;
	logic [XB-1:0]      x_q;
	logic [YB-1:0]      y_q;
	logic [3:0]         k_q;
	logic               bwd_q;
	logic               rdv_s1;
	logic [3:0]         k_s1;
	logic               nv_s1;
	logic [PIX_W-1:0]   ctr_q;
	logic [PIX_W-1:0]   min_q;
	logic [VALUE_W-1:0] value_q;
	logic               status_q;

	logic               img_we;
	logic [AW-1:0]      img_waddr;
	logic [PIX_W-1:0]   img_wdata;
	logic [AW-1:0]      img_raddr;
	logic [PIX_W-1:0]   img_rdata;

	logic               in_range;
	logic               last_idx;
	logic               col_end;
	logic               row_end;
	logic signed [1:0]  dx, dy;
	logic               nv;
	logic [AW-1:0]      row_base;
	logic [AW-1:0]      nb_addr;
	logic [PIX_W-1:0]   relaxed;
	logic               feat;

	cdm_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_img (
		.clk     (clk),
		.wr_en   (img_we),
		.wr_addr (img_waddr),
		.wr_data (img_wdata),
		.rd_addr (img_raddr),
		.rd_data (img_rdata)
	);

	assign in_range = 32'(pix_q) < 32'(n_eff);
	assign last_idx = 32'(idx_q) == 32'(n_eff) - 32'd1;
	assign col_end  = bwd_q ? (x_q == '0) : (32'(x_q) == 32'(w_eff) - 32'd1);
	assign row_end  = bwd_q ? (y_q == '0) : (32'(y_q) == 32'(h_eff) - 32'd1);
	assign feat     = polarity ? (img_rdata != '0) : (img_rdata == '0);

	// neighbor address and whether it lies inside the image
	always_comb begin
		dx = NB_DX[k_q];
		dy = NB_DY[k_q];
		nv = (dx != -2'sd1 || x_q != '0) &&
			(dx != 2'sd1 || 32'(x_q) != 32'(w_eff) - 32'd1) &&
			(dy != -2'sd1 || y_q != '0) &&
			(dy != 2'sd1 || 32'(y_q) != 32'(h_eff) - 32'd1);
		if (dy == -2'sd1) begin
			row_base = idx_q - AW'(w_eff);
		end else if (dy == 2'sd1) begin
			row_base = idx_q + AW'(w_eff);
		end else begin
			row_base = idx_q;
		end
		nb_addr = row_base + AW'(dx);
	end

	always_comb begin
		if (ctr_q == '0) begin
			relaxed = '0;
		end else if (min_q > PIX_SAT) begin
			relaxed = PIX_SAT + PIX_W'(1);
		end else begin
			relaxed = min_q + PIX_W'(1);
		end
	end

	always_comb begin
		state_d        = state_q;
		img_we         = 1'b0;
		img_waddr      = idx_q;
		img_wdata      = relaxed;
		img_raddr      = idx_q;
		hist_cmd.clear = 1'b0;
		hist_cmd.inc   = 1'b0;
		hist_cmd.bin   = bin_q;
		idle           = 1'b0;
		res_valid      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_WRITE: begin
						img_we    = in_range;
						img_waddr = AW'(pix_q);
						img_wdata = val_q;
						state_d   = ST_DONE;
					end
					OP_RUN: begin
						hist_cmd.clear = 1'b1;
						state_d        = ST_MARK_RD;
					end
					OP_READ_PIX: begin
						img_raddr = AW'(pix_q);
						state_d   = in_range ? ST_RD_WAIT : ST_DONE;
					end
					default: begin
						state_d = ST_RD_WAIT;
					end
				endcase
			end
			ST_RD_WAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_MARK_RD: begin
				state_d = ST_MARK_WR;
			end
			ST_MARK_WR: begin
				img_we    = 1'b1;
				img_wdata = feat ? PIX_FEATURE : '0;
				state_d   = last_idx ? ST_RLX_RD : ST_MARK_RD;
			end
			ST_RLX_RD: begin
				img_raddr = nv ? nb_addr : idx_q;
				if (k_q == NB_LAST) begin
					state_d = ST_RLX_LAST;
				end
			end
			ST_RLX_LAST: begin
				state_d = ST_RLX_WR;
			end
			ST_RLX_WR: begin
				img_we       = 1'b1;
				hist_cmd.inc = bwd_q;
				hist_cmd.bin = relaxed;
				if (bwd_q && col_end && row_end) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_RLX_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_value  = value_q;
	assign res_status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdv_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1  <= state_q == ST_RLX_RD;
		end
	end

	always_ff @(posedge clk) begin
		k_s1  <= k_q;
		nv_s1 <= nv;
		// fold in the neighbor read issued in the previous cycle
		if (rdv_s1) begin
			if (k_s1 == '0) begin
				ctr_q <= img_rdata;
				min_q <= img_rdata;
			end else if (nv_s1 && img_rdata < min_q) begin
				min_q <= img_rdata;
			end
		end
		case (state_q)
			ST_IDLE: begin
				op_q  <= req_op;
				pix_q <= req_pix;
				val_q <= req_val;
				bin_q <= req_bin;
			end
			ST_EXEC: begin
				value_q  <= '0;
				status_q <= (op_q == OP_WRITE || op_q == OP_READ_PIX) && !in_range;
				idx_q    <= '0;
			end
			ST_RD_WAIT: begin
				value_q <= (op_q == OP_READ_PIX) ? VALUE_W'(img_rdata) : hist_rdata;
			end
			ST_MARK_WR: begin
				if (!last_idx) begin
					idx_q <= idx_q + AW'(1);
				end else begin
					idx_q <= '0;
				end
				x_q   <= '0;
				y_q   <= '0;
				k_q   <= '0;
				bwd_q <= 1'b0;
			end
			ST_RLX_RD: begin
				k_q <= k_q + 4'd1;
			end
			ST_RLX_WR: begin
				k_q <= '0;
				if (!bwd_q && col_end && row_end) begin
					// backward pass starts on the pixel where the forward pass ended
					bwd_q <= 1'b1;
				end else if (bwd_q) begin
					idx_q <= idx_q - AW'(1);
					if (col_end) begin
						x_q <= XB'(32'(w_eff) - 32'd1);
						y_q <= y_q - YB'(1);
					end else begin
						x_q <= x_q - XB'(1);
					end
				end else begin
					idx_q <= idx_q + AW'(1);
					if (col_end) begin
						x_q <= '0;
						y_q <= y_q + YB'(1);
					end else begin
						x_q <= x_q + XB'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
